// ===== rtl/core/kmer_window_hasher_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the k-mer window hasher
// Shared property forms, clocked on i_clk with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef KMER_WINDOW_HASHER_TOP_ASSERT_SVH
`define KMER_WINDOW_HASHER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define KWH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define KWH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define KWH_ASSERT_NXT_ALL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/kwh_pkg.sv =====
// ---------------------------------------------------------------------------
// kwh_pkg
// Types, constants and helpers shared by the k-mer window hasher modules.
// ---------------------------------------------------------------------------
package kwh_pkg;

    localparam int MAX_KMER = 128;
    localparam int PTR_W    = $clog2(MAX_KMER);
    localparam int KLEN_W   = 8;
    localparam logic [KLEN_W-1:0] KLEN_RESET = 8'd21;
    localparam logic [KLEN_W-1:0] ROLL_MAX_K = 8'd32;

    localparam logic [63:0] MIX_C1   = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2   = 64'h4cf5ad432745937f;
    localparam logic [63:0] FMIX_K1  = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_K2  = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] H1_ADD   = 64'h0000000052dce729;
    localparam logic [63:0] H2_ADD   = 64'h0000000038495ab5;
    localparam logic [63:0] SEED     = 64'd42;

    typedef enum logic [3:0] {
        OP_NOP, OP_ROT, OP_XH, OP_UA, OP_UB, OP_FLEN,
        OP_FA1, OP_FA2, OP_FX, OP_FSH, OP_FH
    } t_op;

    typedef enum logic [1:0] {
        CS_C1, CS_C2, CS_K1, CS_K2
    } t_csel;

    typedef struct packed {
        logic        in_take;
        logic        init;
        logic        clr_x;
        logic        rd_en;
        logic [2:0]  ld_idx;
        logic        mul_go;
        t_csel       csel;
        t_op         op;
        logic        lane;
        logic        out_roll;
        logic        out_mur;
    } t_cmd;

    typedef struct packed {
        logic              take;
        logic              short_k;
        logic [KLEN_W-1:0] ke;
        logic              mul_done;
        logic              out_free;
    } t_sts;

    function automatic logic [1:0] base_code(input logic [7:0] c);
        logic [1:0] v;
        case (c)
            8'h43, 8'h63: v = 2'd1;
            8'h47, 8'h67: v = 2'd2;
            8'h54, 8'h74: v = 2'd3;
            default:      v = 2'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/kwh_ram.sv =====
// ---------------------------------------------------------------------------
// kwh_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/kwh_dpath.sv =====
// ---------------------------------------------------------------------------
// kwh_dpath
// Window store, rolling code, Murmur lanes, shared multiplier, result register.
// ---------------------------------------------------------------------------
module kwh_dpath
    import kwh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [KLEN_W-1:0] i_cfg_wdata,
    input  logic [7:0]        i_nt,
    input  logic              i_fresh,
    input  logic              i_out_ready,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_out_valid,
    output logic [63:0]       o_out_data
);

    logic [KLEN_W-1:0] r_klen;
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [7:0]        r_bases;
    logic [63:0]       r_roll;
    logic [63:0]       r_h1, r_h2, r_x, r_acc;
    logic [1:0]        r_mph;
    logic              r_ld_vld;
    logic [2:0]        r_ld_idx;
    logic              r_out_vld;
    logic [63:0]       r_out_data;

    logic [KLEN_W-1:0] ke;
    logic [7:0]        rd_data;
    logic [31:0]       m_a, m_b;
    logic [63:0]       m_p;
    logic [63:0]       csel_val;
    logic [63:0]       roll_mask;
    logic [63:0]       h1_rot, h2_rot;

    assign ke = (int'(r_klen) > MAX_KMER) ? KLEN_W'(MAX_KMER) : r_klen;

    kwh_ram #(.WIDTH(8), .DEPTH(MAX_KMER)) u_win (
        .i_clk   (i_clk),
        .i_we    (i_cmd.in_take),
        .i_waddr (r_wp),
        .i_wdata (i_nt),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_rp),
        .o_rdata (rd_data)
    );

    always_comb begin
        case (i_cmd.csel)
            CS_C1:   csel_val = MIX_C1;
            CS_C2:   csel_val = MIX_C2;
            CS_K1:   csel_val = FMIX_K1;
            default: csel_val = FMIX_K2;
        endcase
    end

    // 64x64 low product from three 32x32 partials, one per phase
    assign m_a = (r_mph == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign m_b = (r_mph == 2'd1) ? csel_val[63:32] : csel_val[31:0];
    assign m_p = m_a * m_b;

    assign roll_mask = ~({64{1'b1}} << {ke, 1'b0});
    assign h1_rot    = {r_h1[36:0], r_h1[63:37]};
    assign h2_rot    = {r_h2[32:0], r_h2[63:33]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen    <= KLEN_RESET;
            r_wp      <= '0;
            r_bases   <= '0;
            r_roll    <= '0;
            r_mph     <= '0;
            r_ld_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_klen <= i_cfg_wdata;
            end
            if (i_cmd.in_take) begin
                r_wp   <= r_wp + 1'b1;
                r_roll <= ((i_fresh ? 64'd0 : r_roll) << 2) | {62'd0, base_code(i_nt)};
                if (i_fresh) begin
                    r_bases <= 8'd1;
                end else if (r_bases != 8'hff) begin
                    r_bases <= r_bases + 1'b1;
                end
            end
            if (i_cmd.mul_go) begin
                r_mph <= (r_mph == 2'd2) ? 2'd0 : r_mph + 1'b1;
            end
            r_ld_vld <= i_cmd.rd_en;
            if (i_cmd.out_roll || i_cmd.out_mur) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_idx <= i_cmd.ld_idx;
        if (i_cmd.init) begin
            r_rp <= r_wp - PTR_W'(ke);
        end else if (i_cmd.rd_en) begin
            r_rp <= r_rp + 1'b1;
        end

        // working word: byte fill, multiply, rotate, fmix steps
        if (i_cmd.clr_x) begin
            r_x <= '0;
        end else if (r_ld_vld) begin
            r_x <= r_x | ({56'd0, rd_data} << {r_ld_idx, 3'b000});
        end else if (i_cmd.mul_go && r_mph == 2'd2) begin
            r_x <= {r_acc[63:32] + m_p[31:0], r_acc[31:0]};
        end else begin
            case (i_cmd.op)
                OP_ROT: r_x <= i_cmd.lane ? {r_x[30:0], r_x[63:31]}
                                          : {r_x[32:0], r_x[63:33]};
                OP_FX:  r_x <= i_cmd.lane ? r_h2 : r_h1;
                OP_FSH: r_x <= r_x ^ {33'd0, r_x[63:33]};
                default: ;
            endcase
        end

        if (i_cmd.mul_go && r_mph == 2'd0) begin
            r_acc <= m_p;
        end else if (i_cmd.mul_go && r_mph == 2'd1) begin
            r_acc[63:32] <= r_acc[63:32] + m_p[31:0];
        end

        if (i_cmd.init) begin
            r_h1 <= SEED;
            r_h2 <= SEED;
        end else begin
            case (i_cmd.op)
                OP_XH: begin
                    if (i_cmd.lane) r_h2 <= r_h2 ^ r_x;
                    else            r_h1 <= r_h1 ^ r_x;
                end
                OP_UA: begin
                    if (i_cmd.lane) r_h2 <= h2_rot + r_h1;
                    else            r_h1 <= h1_rot + r_h2;
                end
                OP_UB: begin
                    if (i_cmd.lane) r_h2 <= r_h2 + (r_h2 << 2) + H2_ADD;
                    else            r_h1 <= r_h1 + (r_h1 << 2) + H1_ADD;
                end
                OP_FLEN: begin
                    r_h1 <= r_h1 ^ {{(64-KLEN_W){1'b0}}, ke};
                    r_h2 <= r_h2 ^ {{(64-KLEN_W){1'b0}}, ke};
                end
                OP_FA1: r_h1 <= r_h1 + r_h2;
                OP_FA2: r_h2 <= r_h2 + r_h1;
                OP_FH: begin
                    if (i_cmd.lane) r_h2 <= r_x;
                    else            r_h1 <= r_x;
                end
                default: ;
            endcase
        end

        if (i_cmd.out_roll) begin
            r_out_data <= r_roll & roll_mask;
        end else if (i_cmd.out_mur) begin
            r_out_data <= r_h1 + r_h2;
        end
    end

    assign o_sts.take     = (ke != '0) && (r_bases >= ke);
    assign o_sts.short_k  = (ke <= ROLL_MAX_K);
    assign o_sts.ke       = ke;
    assign o_sts.mul_done = i_cmd.mul_go && (r_mph == 2'd2);
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/core/kwh_ctrl.sv =====
// ---------------------------------------------------------------------------
// kwh_ctrl
// Sequencer: accept, pick the hash, walk the Murmur blocks, tail and finish.
// ---------------------------------------------------------------------------
module kwh_ctrl
    import kwh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [23:0] {
        S_IDLE     = 24'h000001,
        S_DECIDE   = 24'h000002,
        S_PUT_ROLL = 24'h000004,
        S_INIT     = 24'h000008,
        S_LSET     = 24'h000010,
        S_LOAD     = 24'h000020,
        S_LWAIT    = 24'h000040,
        S_M1       = 24'h000080,
        S_ROT      = 24'h000100,
        S_M2       = 24'h000200,
        S_XH       = 24'h000400,
        S_UA       = 24'h000800,
        S_UB       = 24'h001000,
        S_FLEN     = 24'h002000,
        S_FA1      = 24'h004000,
        S_FA2      = 24'h008000,
        S_FX       = 24'h010000,
        S_FS1      = 24'h020000,
        S_FM1      = 24'h040000,
        S_FS2      = 24'h080000,
        S_FM2      = 24'h100000,
        S_FS3      = 24'h200000,
        S_FH       = 24'h400000,
        S_PUT_MUR  = 24'h800000
    } t_state;

    t_state     r_state, n_state;
    logic       r_lane, n_lane;
    logic       r_tail, n_tail;
    logic [3:0] r_blk, n_blk;
    logic [3:0] r_cnt, n_cnt;
    logic [3:0] r_n, n_n;

    logic [3:0] nblk, rem, first_n, blk_inc;

    assign nblk    = i_sts.ke[7:4];
    assign rem     = i_sts.ke[3:0];
    assign first_n = (rem > 4'd8) ? 4'd8 : rem;
    assign blk_inc = r_blk + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lane  <= 1'b0;
            r_tail  <= 1'b0;
            r_blk   <= '0;
            r_cnt   <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_lane  <= n_lane;
            r_tail  <= n_tail;
            r_blk   <= n_blk;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
        end
    end

    always_comb begin
        n_state = r_state;
        n_lane  = r_lane;
        n_tail  = r_tail;
        n_blk   = r_blk;
        n_cnt   = r_cnt;
        n_n     = r_n;
        o_cmd   = '0;
        o_cmd.csel = CS_C1;
        o_cmd.op   = OP_NOP;
        o_cmd.lane = r_lane;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.take)        n_state = S_IDLE;
                else if (i_sts.short_k) n_state = S_PUT_ROLL;
                else                    n_state = S_INIT;
            end
            S_PUT_ROLL: begin
                if (i_sts.out_free) begin
                    o_cmd.out_roll = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_blk  = '0;
                n_lane = 1'b0;
                n_tail = 1'b0;
                if (nblk != '0) begin
                    n_n = 4'd8;
                    n_state = S_LSET;
                end else if (rem != '0) begin
                    n_tail = 1'b1;
                    n_n = first_n;
                    n_state = S_LSET;
                end else begin
                    n_state = S_FLEN;
                end
            end
            S_LSET: begin
                o_cmd.clr_x = 1'b1;
                n_cnt = '0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.ld_idx = r_cnt[2:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == r_n - 1'b1) n_state = S_LWAIT;
            end
            S_LWAIT: n_state = S_M1;
            S_M1: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.csel   = r_lane ? CS_C2 : CS_C1;
                if (i_sts.mul_done) n_state = S_ROT;
            end
            S_ROT: begin
                o_cmd.op = OP_ROT;
                n_state = S_M2;
            end
            S_M2: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.csel   = r_lane ? CS_C1 : CS_C2;
                if (i_sts.mul_done) n_state = S_XH;
            end
            S_XH: begin
                o_cmd.op = OP_XH;
                if (!r_tail) begin
                    n_state = S_UA;
                end else if (!r_lane && rem > 4'd8) begin
                    n_lane = 1'b1;
                    n_n = rem - 4'd8;
                    n_state = S_LSET;
                end else begin
                    n_state = S_FLEN;
                end
            end
            S_UA: begin
                o_cmd.op = OP_UA;
                n_state = S_UB;
            end
            S_UB: begin
                o_cmd.op = OP_UB;
                if (!r_lane) begin
                    n_lane = 1'b1;
                    n_n = 4'd8;
                    n_state = S_LSET;
                end else begin
                    n_lane = 1'b0;
                    n_blk  = blk_inc;
                    if (blk_inc < nblk) begin
                        n_n = 4'd8;
                        n_state = S_LSET;
                    end else if (rem != '0) begin
                        n_tail = 1'b1;
                        n_n = first_n;
                        n_state = S_LSET;
                    end else begin
                        n_state = S_FLEN;
                    end
                end
            end
            S_FLEN: begin
                o_cmd.op = OP_FLEN;
                n_state = S_FA1;
            end
            S_FA1: begin
                o_cmd.op = OP_FA1;
                n_state = S_FA2;
            end
            S_FA2: begin
                o_cmd.op = OP_FA2;
                n_lane = 1'b0;
                n_state = S_FX;
            end
            S_FX: begin
                o_cmd.op = OP_FX;
                n_state = S_FS1;
            end
            S_FS1: begin
                o_cmd.op = OP_FSH;
                n_state = S_FM1;
            end
            S_FM1: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.csel   = CS_K1;
                if (i_sts.mul_done) n_state = S_FS2;
            end
            S_FS2: begin
                o_cmd.op = OP_FSH;
                n_state = S_FM2;
            end
            S_FM2: begin
                o_cmd.mul_go = 1'b1;
                o_cmd.csel   = CS_K2;
                if (i_sts.mul_done) n_state = S_FS3;
            end
            S_FS3: begin
                o_cmd.op = OP_FSH;
                n_state = S_FH;
            end
            S_FH: begin
                o_cmd.op = OP_FH;
                if (!r_lane) begin
                    n_lane = 1'b1;
                    n_state = S_FX;
                end else begin
                    n_state = S_PUT_MUR;
                end
            end
            S_PUT_MUR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_mur = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/kmer_window_hasher_top.sv =====
// ---------------------------------------------------------------------------
// kmer_window_hasher_top
// Streaming k-mer hasher: 2-bit rolling code for short k, Murmur3 otherwise.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel takes one base per request: tdata = nucleotide byte,
//   tuser = new_sequence (restart the base count before this base).
//   Master channel returns one 64-bit hash per request once k bases of the
//   current sequence are in; fewer bases give no result.
//   kmer_length is written through i_cfg_we / i_cfg_wdata while idle.
//   One base is handled at a time. With no result due, the block passes
//   through its decide state back to idle before it takes the next base.
//   For k up to 32 the masked rolling code goes to the output register
//   once that is free. For larger k the window bytes are read one per
//   cycle from the window RAM and mixed on a single 32x32 multiplier:
//   each 8-byte word is multiplied, rotated, multiplied and XORed into its
//   lane, lane updates follow each 16-byte block, then fmix finishes.
//   A finished hash sits in the output register; the next base is accepted
//   while it waits, and the block holds only if the next hash is ready
//   before the receiver takes the previous one.
//   Reset clears the base count, rolling code and output valid, and sets
//   k to 21; window contents are not cleared.
// ---------------------------------------------------------------------------
module kmer_window_hasher_top
    import kwh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: tdata = nucleotide[7:0]
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // tuser = new_sequence[0]
    input  logic [0:0]  i_s_axis_tuser,
    // master side: tdata = kmer_hash[63:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,
    // configuration: kmer_length
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: owns the input handshake and the Murmur step order
    kwh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: window RAM, rolling code, hash lanes and result register
    kwh_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_nt        (i_s_axis_tdata),
        .i_fresh     (i_s_axis_tuser[0]),
        .i_out_ready (i_m_axis_tready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

// ===== rtl/core/kwh_checker.sv =====
// ---------------------------------------------------------------------------
// kwh_checker
// Port-level checks on the k-mer window hasher, bound to the top level.
// ---------------------------------------------------------------------------
`include "kmer_window_hasher_top_assert.svh"

module kwh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic        i_cfg_we,
    input logic [7:0]  i_cfg_wdata
);

    `KWH_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result dropped or changed while stalled")
    `KWH_ASSERT_NXT_ALL(a_rst_empty, !i_rst_n, !o_m_axis_tvalid && o_s_axis_tready, "result or busy after reset")
    `KWH_ASSERT_NXT(a_one_at_a_time, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "request taken while busy")
    `KWH_ASSERT_IMP(a_result_after_work, $rose(o_m_axis_tvalid), $past(!o_s_axis_tready), "result without a request in work")

endmodule

bind kmer_window_hasher_top kwh_checker u_kwh_checker (.*);

// ===== tb/sv/kmer_window_hasher_checker.sv =====
// ---------------------------------------------------------------------------
// kmer_window_hasher_checker
// Watches both stream channels of the k-mer hasher, predicts each hash from
// the accepted bases and compares it with what the block returns.
// ---------------------------------------------------------------------------
module kmer_window_hasher_checker
    import kwh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [7:0]  i_s_data,
    input  logic [0:0]  i_s_user,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [63:0] i_m_data,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_hashes_seen
);

    logic [7:0]  klen;
    logic [7:0]  win [MAX_KMER];
    logic [7:0]  count;
    logic [63:0] code;
    logic [63:0] hash_q [$];

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] fmix(input logic [63:0] v);
        v ^= v >> 33;
        v = v * FMIX_K1;
        v ^= v >> 33;
        v = v * FMIX_K2;
        v ^= v >> 33;
        return v;
    endfunction

    function automatic logic [63:0] word_at(input int base, input int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v |= 64'(win[base + i]) << (8 * i);
        return v;
    endfunction

    function automatic logic [63:0] murmur_hash(input int len);
        logic [63:0] h1, h2, a, c;
        int          start, nb, rem, t;
        h1 = SEED;
        h2 = SEED;
        start = MAX_KMER - len;
        nb = len / 16;
        rem = len % 16;
        for (int b = 0; b < nb; b++) begin
            a = word_at(start + 16 * b, 8);
            c = word_at(start + 16 * b + 8, 8);
            a = a * MIX_C1; a = rotl(a, 31); a = a * MIX_C2; h1 ^= a;
            h1 = rotl(h1, 27); h1 += h2; h1 = h1 * 5 + H1_ADD;
            c = c * MIX_C2; c = rotl(c, 33); c = c * MIX_C1; h2 ^= c;
            h2 = rotl(h2, 31); h2 += h1; h2 = h2 * 5 + H2_ADD;
        end
        t = start + 16 * nb;
        if (rem > 8) begin
            c = word_at(t + 8, rem - 8);
            c = c * MIX_C2; c = rotl(c, 33); c = c * MIX_C1; h2 ^= c;
        end
        if (rem > 0) begin
            a = word_at(t, rem > 8 ? 8 : rem);
            a = a * MIX_C1; a = rotl(a, 31); a = a * MIX_C2; h1 ^= a;
        end
        h1 ^= 64'(len);
        h2 ^= 64'(len);
        h1 += h2;
        h2 += h1;
        h1 = fmix(h1);
        h2 = fmix(h2);
        return h1 + h2;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        o_errors++;
    endtask

    // Advance the window with one base; queue a hash if k bases are in.
    task automatic take_base(input logic [7:0] nt, input logic fresh);
        int k;
        k = (klen > MAX_KMER) ? MAX_KMER : klen;
        if (fresh) begin
            count = 0;
            code = 0;
        end
        for (int i = 0; i < MAX_KMER - 1; i++)
            win[i] = win[i + 1];
        win[MAX_KMER - 1] = nt;
        code = (code << 2) | 64'(base_code(nt));
        if (count != 8'd255)
            count++;
        if (k == 0 || count < k)
            return;
        if (k <= 32)
            hash_q.insert(hash_q.size(),
                          k == 32 ? code : code & ((64'd1 << (2 * k)) - 1));
        else
            hash_q.insert(hash_q.size(), murmur_hash(k));
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_hashes_seen = 0;
        klen = KLEN_RESET;
        count = 0;
        code = 0;
        foreach (win[i]) win[i] = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            klen <= KLEN_RESET;
            count = 0;
            code = 0;
            hash_q.delete();
        end else begin
            // compare the result first: it cannot stem from a base taken now
            if (i_m_valid && i_m_ready) begin
                o_hashes_seen++;
                if (hash_q.size() == 0)
                    report_mismatch($sformatf("unexpected hash %h", i_m_data));
                else if (hash_q[0] !== i_m_data) begin
                    report_mismatch($sformatf("hash got %h want %h", i_m_data, hash_q[0]));
                    void'(hash_q.pop_front());
                end else
                    void'(hash_q.pop_front());
            end
            if (i_s_valid && i_s_ready)
                take_base(i_s_data, i_s_user[0]);
            if (i_cfg_we)
                klen <= i_cfg_wdata;
        end
        o_pending = hash_q.size();
    end

endmodule

// ===== tb/sv/kmer_window_hasher_top_tb.sv =====
// ---------------------------------------------------------------------------
// kmer_window_hasher_top_tb
// Drives bases through the k-mer hasher over a range of k settings, with
// random gaps and back-pressure, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module kmer_window_hasher_top_tb;
    import kwh_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data;
    logic [0:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_data;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    int          errors;
    int          pending;
    int          hashes_seen;
    int          idle_cycles;
    bit          calm;      // no random gaps on either side
    bit          hold_off;  // receiver holds off for a long stretch

    kmer_window_hasher_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    kmer_window_hasher_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_valid     (s_valid),
        .i_s_ready     (s_ready),
        .i_s_data      (s_data),
        .i_s_user      (s_user),
        .i_m_valid     (m_valid),
        .i_m_ready     (m_ready),
        .i_m_data      (m_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_hashes_seen (hashes_seen)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Random receiver stalls, none in calm stretches; ready stays low while holding off.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off)
                m_ready <= 1'b0;
            else
                m_ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // Watchdog: count cycles in which no request moves on either side.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_n)
                idle_cycles = 0;
            else if (++idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[kmer_window_hasher_top] ERROR");
                $finish;
            end
        end
    end

    // Offer one base and hold it until the block accepts it; valid stays
    // high afterwards, so the next base can follow with no gap.
    task automatic send_base(input logic [7:0] nt, input logic fresh);
        while (!calm && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= nt;
        s_user  <= fresh;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly A/C/G/T in either case, sometimes any byte.
    function automatic logic [7:0] rand_base();
        logic [7:0] bases [8] = '{"A", "C", "G", "T", "a", "c", "g", "t"};
        if ($urandom_range(9) == 0)
            return 8'($urandom);
        return bases[$urandom_range(7)];
    endfunction

    // Drop valid, drain all outstanding hashes, wait out the block, write k.
    task automatic set_kmer_length(input logic [7:0] k);
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Send a sequence of n random bases, starting a new one.
    task automatic send_sequence(input int n);
        for (int i = 0; i < n; i++)
            send_base(rand_base(), i == 0);
    endtask

    initial begin
        logic [7:0] klist [10] = '{8'd1, 8'd32, 8'd33, 8'd128, 8'd255,
                                   8'd0, 8'd16, 8'd48, 8'd7, 8'd21};
        string pat = "ACGTacgtN";
        int k;
        int n;

        rst_n     = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        s_user    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        calm      = 1'b0;
        hold_off  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset k of 21, extreme bytes, short sequence, restart.
        for (int i = 0; i < 22; i++)
            send_base(i == 0 ? 8'h00 : (i == 1 ? 8'hff : pat[i % 9]), i == 0);
        send_base("G", 1'b1);
        send_base("t", 1'b0);

        // k of 32 at the boundary, then a change of k mid-sequence.
        set_kmer_length(8'd32);
        send_sequence(34);
        set_kmer_length(8'd4);
        send_base("C", 1'b0);
        send_base("g", 1'b0);

        // Back-pressure: hold the receiver while bases keep coming.
        set_kmer_length(8'd2);
        hold_off <= 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off <= 1'b0;
            end
            send_sequence(20);
        join

        // Random phases over several settings, extremes among them.
        for (int p = 0; p < 10; p++) begin
            k = klist[p];
            set_kmer_length(8'(k));
            calm <= (p == 4);
            n = (k > 32) ? 6 : 10;
            send_sequence(((k == 0) ? 10 : ((k > 128) ? 128 : k)) + $urandom_range(n));
        end
        calm <= 1'b0;
        // Some random short sequences under the final k.
        for (int r = 0; r < 2 && hashes_seen < 500; r++)
            send_sequence($urandom_range(1, 30));
        s_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        if (errors == 0)
            $display("[kmer_window_hasher_top] OK");
        else
            $display("[kmer_window_hasher_top] ERROR");
        $finish;
    end

endmodule
